>>> sv/sgr_pkg.sv
// Package: shared constants for the sandpile grain relaxation block.
`timescale 1ns / 1ps

package sgr_pkg;

  // Default grid size (interior cells)
  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  // Stored height width; heights stay at 7 or below while relaxing
  localparam int HEIGHT_W = 3;

  // Height at which a cell topples
  localparam logic [HEIGHT_W-1:0] TOPPLE_AT = 3'd4;

  // Field widths on the stream ports
  localparam int COUNT_W = 32;
  localparam int CELL_W  = 6;
  localparam int OUT_H_W = 2;

endpackage

>>> sv/sgr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps

module sgr_ram
  import sgr_pkg::*;
#(
  parameter int WIDTH = HEIGHT_W,
  parameter int DEPTH = GRID_ROWS_DEF * GRID_COLS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sandpile_grain_relax.sv
// Top level: sandpile grid with grain drop, in-place relaxation sweeps and cell read.
//
//  channel | dir | signals                      | request contents
//  --------+-----+------------------------------+-----------------------------------------
//  s       | in  | s_tvalid s_tready s_tdata    | mode, cell_row, cell_col
//  m       | out | m_tvalid m_tready m_tdata    | topple_count, cell_height
//
// Flow: a read passes through S_FIN_RD, S_FIN_DATA and S_OUT. A drop reads and
// rewrites its cell in S_DROP_RD and S_DROP_WR, then runs row-major sweeps;
// each sweep visits every cell and, per topple, reads and writes each in-grid
// neighbor and skips each off-grid one; sweeps repeat until one topples nothing.
// The single RAM port pair serializes these accesses. One request is worked at a time.
// Reset: a clearing pass over all GRID_ROWS*GRID_COLS cells zeroes the grid;
// s_tready stays low until it ends. A stalled m side holds the finished
// result in its output register, and the next request may be taken
// meanwhile.
`timescale 1ns / 1ps

module sandpile_grain_relax
  import sgr_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] mode, [6:1] cell_row, [12:7] cell_col, [15:13] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] topple_count, [33:32] cell_height, [39:34] zero
);

  localparam int DEPTH  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RW     = $clog2(GRID_ROWS);
  localparam int CW     = $clog2(GRID_COLS);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [RW-1:0]     LAST_ROW  = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0]     LAST_COL  = CW'(GRID_COLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GRID_COLS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DROP_RD, S_DROP_WR, S_SCAN, S_CHECK,
    S_NB_RD, S_NB_WR, S_FIN_RD, S_FIN_DATA, S_OUT
  } state_t;

  typedef enum logic [1:0] {NB_DOWN, NB_UP, NB_RIGHT, NB_LEFT} nb_t;

  state_t                state;
  nb_t                   nb;
  logic [ADDR_W-1:0]     idx;
  logic [RW-1:0]         row;
  logic [CW-1:0]         col;
  logic [ADDR_W-1:0]     tgt;
  logic                  changed;
  logic [COUNT_W-1:0]    count;
  logic [OUT_H_W-1:0]    hgt;

  // Request fields
  logic              in_mode;
  logic [CELL_W-1:0] in_row;
  logic [CELL_W-1:0] in_col;
  logic              in_inside;
  logic [ADDR_W-1:0] in_addr;

  // RAM ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [HEIGHT_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [HEIGHT_W-1:0] ram_rdata;

  // Neighbor address and whether it lies inside the grid
  logic [ADDR_W-1:0] nb_addr;
  logic              nb_ok;
  logic              adv;
  logic              topple;
  logic              out_load;

  assign in_mode   = s_tdata[0];
  assign in_row    = s_tdata[6:1];
  assign in_col    = s_tdata[12:7];
  assign in_inside = (int'(in_row) < GRID_ROWS) && (int'(in_col) < GRID_COLS);
  assign in_addr   = ADDR_W'(ADDR_W'(in_row) * ROW_STEP + ADDR_W'(in_col));

  assign s_tready = (state == S_IDLE);
  assign topple   = (ram_rdata >= TOPPLE_AT);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (nb)
      NB_DOWN: begin
        nb_addr = idx + ROW_STEP;
        nb_ok   = (row != LAST_ROW);
      end
      NB_UP: begin
        nb_addr = idx - ROW_STEP;
        nb_ok   = (row != '0);
      end
      NB_RIGHT: begin
        nb_addr = idx + ADDR_W'(1);
        nb_ok   = (col != LAST_COL);
      end
      NB_LEFT: begin
        nb_addr = idx - ADDR_W'(1);
        nb_ok   = (col != '0);
      end
      default: begin
        nb_addr = idx;
        nb_ok   = 1'b0;
      end
    endcase
  end

  // Move on to the next cell after this visit
  always_comb begin
    case (state)
      S_CHECK: adv = !topple;
      S_NB_RD: adv = !nb_ok && (nb == NB_LEFT);
      S_NB_WR: adv = (nb == NB_LEFT);
      default: adv = 1'b0;
    endcase
  end

  // RAM port control per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_raddr = idx;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_DROP_RD, S_FIN_RD: begin
        ram_raddr = tgt;
      end
      S_DROP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = tgt;
        ram_wdata = ram_rdata + HEIGHT_W'(1);
      end
      S_CHECK: begin
        ram_we    = topple;
        ram_wdata = ram_rdata - TOPPLE_AT;
      end
      S_NB_RD: begin
        ram_raddr = nb_addr;
      end
      S_NB_WR: begin
        ram_we    = 1'b1;
        ram_waddr = nb_addr;
        ram_wdata = ram_rdata + HEIGHT_W'(1);
      end
      S_IDLE, S_SCAN, S_FIN_DATA, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  sgr_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer, position counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      idx      <= '0;
      row      <= '0;
      col      <= '0;
      nb       <= NB_DOWN;
      changed  <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Load a finished result, drop it once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_ADDR) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            tgt   <= in_addr;
            count <= '0;
            hgt   <= '0;
            if (in_inside && !in_mode) begin
              state <= S_DROP_RD;
            end else if (in_inside) begin
              state <= S_FIN_RD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_DROP_RD: begin
          state <= S_DROP_WR;
        end
        S_DROP_WR: begin
          idx     <= '0;
          row     <= '0;
          col     <= '0;
          changed <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (topple) begin
            changed <= 1'b1;
            if (count != '1) begin
              count <= count + COUNT_W'(1);
            end
            nb    <= NB_DOWN;
            state <= S_NB_RD;
          end
        end
        S_NB_RD: begin
          if (nb_ok) begin
            state <= S_NB_WR;
          end else if (nb != NB_LEFT) begin
            nb <= nb_t'(nb + 2'd1);
          end
        end
        S_NB_WR: begin
          if (nb != NB_LEFT) begin
            nb    <= nb_t'(nb + 2'd1);
            state <= S_NB_RD;
          end
        end
        S_FIN_RD: begin
          state <= S_FIN_DATA;
        end
        S_FIN_DATA: begin
          hgt   <= ram_rdata[OUT_H_W-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_tdata <= {6'b0, hgt, count};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Step to the next cell; at the end of a sweep, repeat or finish
      if (adv) begin
        if (col == LAST_COL) begin
          col <= '0;
          if (row == LAST_ROW) begin
            row <= '0;
            idx <= '0;
            if (changed) begin
              changed <= 1'b0;
              state   <= S_SCAN;
            end else begin
              state <= S_FIN_RD;
            end
          end else begin
            row   <= row + RW'(1);
            idx   <= idx + ADDR_W'(1);
            state <= S_SCAN;
          end
        end else begin
          col   <= col + CW'(1);
          idx   <= idx + ADDR_W'(1);
          state <= S_SCAN;
        end
      end
    end
  end

endmodule

>>> tb/tb_sandpile_grain_relax.sv
// Testbench for the sandpile grain relaxation block: drops and reads checked against a grid model.
`timescale 1ns / 1ps

module tb_sandpile_grain_relax;
  import sgr_pkg::*;

  localparam int ROWS = GRID_ROWS_DEF;
  localparam int COLS = GRID_COLS_DEF;

  // Request modes
  localparam logic MODE_DROP = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam int IDLE_PCT     = 12;
  localparam int LONG_HOLD    = 800;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 40_000_000;
  localparam int RANDOM_REQS  = 65;

  // Request as packed on s_tdata, mode in the lowest bit
  typedef struct packed {
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic              mode;
  } grain_req_t;

  typedef struct {
    logic [COUNT_W-1:0] topples;
    logic [OUT_H_W-1:0] height;
  } pile_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // [0] mode, [6:1] cell_row, [12:7] cell_col, [15:13] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // [31:0] topple_count, [33:32] cell_height, [39:34] zero

  // Predicted grid and bookkeeping
  logic [HEIGHT_W-1:0] pile_h [ROWS][COLS];
  grain_req_t   req_q[$];
  pile_result_t pile_results_q[$];
  int  reqs_taken = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  hold_go = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;

  sandpile_grain_relax #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One grain to a neighbor; off-grid neighbors are sinks
  function automatic void add_grain(int r, int c);
    if (r >= 0 && r < ROWS && c >= 0 && c < COLS) begin
      pile_h[r][c] = pile_h[r][c] + 1'b1;
    end
  endfunction

  // Drop a grain and relax in row-major sweeps, or just read a cell
  function automatic pile_result_t apply_request(grain_req_t req);
    pile_result_t res;
    logic [COUNT_W-1:0] count;
    bit on_grid;
    bit changed;
    count   = '0;
    on_grid = (int'(req.row) < ROWS) && (int'(req.col) < COLS);
    if (req.mode == MODE_DROP && on_grid) begin
      add_grain(req.row, req.col);
      do begin
        changed = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < COLS; c++) begin
            if (pile_h[r][c] >= TOPPLE_AT) begin
              pile_h[r][c] = pile_h[r][c] - TOPPLE_AT;
              add_grain(r + 1, c);
              add_grain(r - 1, c);
              add_grain(r, c + 1);
              add_grain(r, c - 1);
              if (count != '1) count = count + 1'b1;
              changed = 1'b1;
            end
          end
        end
      end while (changed);
    end
    res.topples = count;
    res.height  = on_grid ? pile_h[req.row][req.col][OUT_H_W-1:0] : '0;
    return res;
  endfunction

  function automatic void report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Sender: offers queued requests, idling at random outside the steady window
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pile_results_q.push_back(apply_request(s_tdata[2*CELL_W:0]));
        reqs_taken <= reqs_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (req_q.size() != 0 &&
            ((reqs_taken >= 55 && reqs_taken < 75) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {3'b000, req_q.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= LONG_HOLD;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= (results_seen >= 55 && results_seen < 75) ||
                  ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : monitor
    pile_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (pile_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d height=%0d",
                                  m_tdata[31:0], m_tdata[33:32]));
      end else begin
        want = pile_results_q.pop_front();
        if (m_tdata[31:0] !== want.topples || m_tdata[33:32] !== want.height) begin
          report_mismatch($sformatf("result %0d: count exp %0d got %0d, height exp %0d got %0d",
                                    results_seen, want.topples, m_tdata[31:0],
                                    want.height, m_tdata[33:32]));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_req(logic mode, int row, int col);
    grain_req_t req;
    req.mode = mode;
    req.row  = row[CELL_W-1:0];
    req.col  = col[CELL_W-1:0];
    req_q.push_back(req);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || s_tvalid || pile_results_q.size() != 0) @(negedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    int roll;
    int r;
    int c;
    bit far_zone;
    for (int i = 0; i < ROWS; i++)
      for (int j = 0; j < COLS; j++)
        pile_h[i][j] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corners, build-up to topples at the edge and in the interior
    push_req(MODE_READ, 0, 0);
    push_req(MODE_READ, 63, 63);
    repeat (3) push_req(MODE_DROP, 0, 0);
    push_req(MODE_READ, 0, 0);
    push_req(MODE_DROP, 0, 0);
    repeat (4) push_req(MODE_DROP, 63, 63);
    repeat (4) push_req(MODE_DROP, 31, 32);
    push_req(MODE_READ, 30, 32);
    push_req(MODE_DROP, 0, 63);
    push_req(MODE_DROP, 63, 0);
    push_req(MODE_READ, 63, 0);
    repeat (3) push_req(MODE_DROP, 1, 0);
    push_req(MODE_READ, 0, 1);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      // Sender pause, then a long receiver hold while fast reads pile up
      if (n == 30) begin
        wait_drained();
        hold_go = 1'b1;
        repeat (12) push_req(MODE_READ, $urandom_range(0, 63), $urandom_range(0, 63));
      end
      roll     = $urandom_range(0, 99);
      far_zone = $urandom_range(0, 1);
      r = far_zone ? 63 - $urandom_range(0, 3) : $urandom_range(0, 3);
      c = far_zone ? 63 - $urandom_range(0, 3) : $urandom_range(0, 3);
      if (roll < 45) begin
        // hot corners keep avalanches frequent
        push_req(MODE_DROP, r, c);
      end else if (roll < 65) begin
        push_req(MODE_DROP, $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (roll < 85) begin
        push_req(MODE_READ, r, c);
      end else begin
        push_req(MODE_READ, $urandom_range(0, 63), $urandom_range(0, 63));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pile_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
